// ----- hw/rtl/clb_pkg.sv -----
// Shared types, constants and helper functions for the character LCD bus controller.
`timescale 1ns / 1ps
`default_nettype none

package clb_pkg;

    // Default width of the per-part tick counter
    localparam int TICK_BITS_DEF = 17;

    // Width of the longest duration register
    localparam int DUR_W = 17;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETUP       = 3'd0,
        CFG_PULSE       = 3'd1,
        CFG_HOLD        = 3'd2,
        CFG_FIRST_WAIT  = 3'd3,
        CFG_SECOND_WAIT = 3'd4
    } cfg_idx_t;

    // Host request codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_INSTR = 2'd1;
    localparam logic [1:0] ACT_CHAR  = 2'd2;
    localparam logic [1:0] ACT_POS   = 2'd3;

    // Power-up instruction bytes
    localparam logic [7:0] CMD_WAKE     = 8'h30;
    localparam logic [7:0] CMD_FUNC_SET = 8'h38;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0c;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;

    // Set-DDRAM-address opcode bit and second-line offset
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;

    // Init step counter; all-ones marks the sequence as done
    localparam logic [2:0] INIT_DONE = 3'd7;

    // Bus-cycle parts, one-hot
    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_RD_SETUP = 8'b0000_0010,
        PH_RD_PULSE = 8'b0000_0100,
        PH_RD_HOLD  = 8'b0000_1000,
        PH_WR_SETUP = 8'b0001_0000,
        PH_WR_PULSE = 8'b0010_0000,
        PH_WR_HOLD  = 8'b0100_0000,
        PH_WAIT     = 8'b1000_0000
    } phase_t;

    // Timing registers
    typedef struct packed {
        logic [7:0]       setup;
        logic [7:0]       pulse;
        logic [7:0]       hold;
        logic [DUR_W-1:0] first_wait;
        logic [DUR_W-1:0] second_wait;
    } cfg_t;

    // Sequencer control state
    typedef struct packed {
        phase_t     phase;
        logic [2:0] init_step;
        logic       pending_rs;
        logic [7:0] pending_byte;
        logic       busy_seen;
    } ctl_t;

    // LCD pin levels
    typedef struct packed {
        logic       e;
        logic       rw;
        logic       rs;
        logic [7:0] data;
    } pins_t;

    // Instruction byte written at each power-up step
    function automatic logic [7:0] init_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0, 3'd1, 3'd2: b = CMD_WAKE;
            3'd3:             b = CMD_FUNC_SET;
            3'd4:             b = CMD_DISP_ON;
            3'd5:             b = CMD_CLEAR;
            3'd6:             b = CMD_ENTRY;
            default:          b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/clb_step.sv -----
// Next-state logic for one tick of the LCD bus sequencer.
`timescale 1ns / 1ps
`default_nettype none

module clb_step
    import clb_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_BITS_DEF
) (
    input  var cfg_t                         cfg,
    input  var ctl_t                         ctl,
    input  var pins_t                        pins,
    input  wire [TICK_COUNTER_BITS-1:0]      tick,
    input  wire [1:0]                        action,
    input  wire [7:0]                        req_value,
    input  wire [7:0]                        lcd_data_in,
    output ctl_t                             ctl_next,
    output pins_t                            pins_next,
    output logic [TICK_COUNTER_BITS-1:0]     tick_next,
    output logic                             accepted,
    output logic                             ready
);

    localparam int CW = (TICK_COUNTER_BITS > DUR_W) ? TICK_COUNTER_BITS : DUR_W;
    localparam logic [TICK_COUNTER_BITS-1:0] TICK_MAX = '1;

    logic                         req_take;
    phase_t                       enter_rd;
    phase_t                       enter_wr;
    phase_t                       ph_cur;
    logic [7:0]                   byte_cur;
    logic                         rs_cur;
    logic                         busy_new;
    logic [DUR_W-1:0]             dur;
    logic [TICK_COUNTER_BITS-1:0] tick_base;
    logic [TICK_COUNTER_BITS-1:0] tick_inc;
    logic                         part_end;
    phase_t                       after_rd_hold;
    phase_t                       after_wr_hold;
    logic [2:0]                   step_wr_hold;
    logic [2:0]                   step_inc;
    logic [DUR_W-1:0]             wait_dur;
    phase_t                       ph_after;
    logic [2:0]                   step_after;

    assign req_take = (ctl.phase == PH_IDLE) && (ctl.init_step == INIT_DONE)
                      && (action != ACT_TICK);

    // Zero-length setup parts are skipped straight into the pulse
    assign enter_rd = (cfg.setup == 8'd0) ? PH_RD_PULSE : PH_RD_SETUP;
    assign enter_wr = (cfg.setup == 8'd0) ? PH_WR_PULSE : PH_WR_SETUP;

    assign ph_cur    = req_take ? enter_rd : ctl.phase;
    assign tick_base = req_take ? '0 : tick;

    // Latch the request
    always_comb
    begin
        byte_cur = ctl.pending_byte;
        rs_cur   = ctl.pending_rs;
        if (req_take)
        begin
            case (action)
                ACT_POS:
                begin
                    byte_cur = CMD_SET_ADDR
                             | (req_value[4] ? LINE2_OFFSET : 8'h00)
                             | {4'h0, req_value[3:0]};
                    rs_cur   = 1'b0;
                end
                ACT_CHAR:
                begin
                    byte_cur = req_value;
                    rs_cur   = 1'b1;
                end
                default:
                begin
                    byte_cur = req_value;
                    rs_cur   = 1'b0;
                end
            endcase
        end
    end

    assign busy_new = (ph_cur == PH_RD_PULSE) ? lcd_data_in[7] : ctl.busy_seen;

    // Pin levels for this tick
    always_comb
    begin
        pins_next = pins;
        unique case (ph_cur)
            PH_RD_SETUP, PH_RD_HOLD:
            begin
                pins_next.e  = 1'b0;
                pins_next.rw = 1'b1;
                pins_next.rs = 1'b0;
            end
            PH_RD_PULSE:
            begin
                pins_next.e  = 1'b1;
                pins_next.rw = 1'b1;
                pins_next.rs = 1'b0;
            end
            PH_WR_SETUP, PH_WR_HOLD, PH_WR_PULSE:
            begin
                pins_next.e  = (ph_cur == PH_WR_PULSE);
                pins_next.rw = 1'b0;
                if (ctl.init_step != INIT_DONE)
                begin
                    pins_next.data = init_byte(ctl.init_step);
                    pins_next.rs   = 1'b0;
                end
                else
                begin
                    pins_next.data = byte_cur;
                    pins_next.rs   = rs_cur;
                end
            end
            default:
            begin
                pins_next.e = 1'b0;
            end
        endcase
    end

    // Length of the current part
    always_comb
    begin
        unique case (ph_cur)
            PH_RD_SETUP, PH_WR_SETUP: dur = DUR_W'(cfg.setup);
            PH_RD_PULSE, PH_WR_PULSE:
                dur = (cfg.pulse == 8'd0) ? DUR_W'(1) : DUR_W'(cfg.pulse);
            PH_RD_HOLD, PH_WR_HOLD:   dur = DUR_W'(cfg.hold);
            PH_WAIT:
                dur = (ctl.init_step == 3'd1) ? cfg.first_wait : cfg.second_wait;
            default:                  dur = DUR_W'(1);
        endcase
    end

    assign tick_inc = (tick_base != TICK_MAX) ? tick_base + TICK_COUNTER_BITS'(1) : tick_base;
    assign part_end = (CW'(tick_inc) >= CW'(dur)) || (tick_inc == TICK_MAX);

    // Successors, with zero-length parts skipped
    assign after_rd_hold = busy_new ? enter_rd : enter_wr;

    assign step_inc = ctl.init_step + 3'd1;
    assign wait_dur = (step_inc == 3'd1) ? cfg.first_wait : cfg.second_wait;

    always_comb
    begin
        if (ctl.init_step == INIT_DONE)
        begin
            after_wr_hold = PH_IDLE;
            step_wr_hold  = ctl.init_step;
        end
        else
        begin
            step_wr_hold = step_inc;
            if (step_inc <= 3'd2)
                after_wr_hold = (wait_dur == '0) ? enter_wr : PH_WAIT;
            else if (step_inc != INIT_DONE)
                after_wr_hold = enter_rd;
            else
                after_wr_hold = PH_IDLE;
        end
    end

    always_comb
    begin
        step_after = ctl.init_step;
        unique case (ph_cur)
            PH_RD_SETUP: ph_after = PH_RD_PULSE;
            PH_RD_PULSE: ph_after = (cfg.hold != 8'd0) ? PH_RD_HOLD : after_rd_hold;
            PH_RD_HOLD:  ph_after = after_rd_hold;
            PH_WR_SETUP: ph_after = PH_WR_PULSE;
            PH_WR_PULSE:
            begin
                if (cfg.hold != 8'd0)
                    ph_after = PH_WR_HOLD;
                else
                begin
                    ph_after   = after_wr_hold;
                    step_after = step_wr_hold;
                end
            end
            PH_WR_HOLD:
            begin
                ph_after   = after_wr_hold;
                step_after = step_wr_hold;
            end
            PH_WAIT:     ph_after = enter_wr;
            default:     ph_after = PH_IDLE;
        endcase
    end

    // Advance the part when its count runs out
    always_comb
    begin
        ctl_next              = ctl;
        ctl_next.pending_byte = byte_cur;
        ctl_next.pending_rs   = rs_cur;
        ctl_next.busy_seen    = busy_new;
        ctl_next.phase        = ph_cur;
        tick_next             = tick_base;
        if (ph_cur != PH_IDLE)
        begin
            tick_next = tick_inc;
            if (part_end)
            begin
                ctl_next.phase     = ph_after;
                ctl_next.init_step = step_after;
                tick_next          = '0;
            end
        end
    end

    assign accepted = req_take;
    assign ready    = (ctl_next.phase == PH_IDLE) && (ctl_next.init_step == INIT_DONE);

endmodule

`default_nettype wire

// ----- hw/rtl/char_lcd_bus_controller.sv -----
// Top level of the character LCD bus controller: registers, config port, output stage.
`timescale 1ns / 1ps
`default_nettype none

// Pin-level sequencer for an 8-bit character LCD. Each accepted input item is
// one bus tick: it carries the sampled LCD data bus and an optional host
// request (write instruction, write character, set cursor position). Each
// item yields exactly one result item with the pin levels for that tick, an
// accepted flag for the request and a ready flag. After reset the block runs
// the power-up sequence (0x30 three times with two programmed waits, then
// 0x38, 0x0c, 0x01, 0x06 with busy polling) before it takes requests; a
// request that arrives while the block is busy is dropped and reported as
// not accepted. Rate: one item per clock cycle, set by the single tick update
// that feeds the state registers, which also hold the result; an item is
// accepted while the previous result is still waiting, as long as that result
// is not stalled. The result is valid in the cycle after its input is accepted.
// Timing registers are written through the plain write port and should only
// be changed while no request is in flight.
module char_lcd_bus_controller
    import clb_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_BITS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,

    // Input item channel
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire [1:0]             action,
    input  wire [7:0]             req_value,
    input  wire [7:0]             lcd_data_in,

    // Result item channel
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic                  lcd_e,
    output logic                  lcd_rw,
    output logic                  lcd_rs,
    output logic [7:0]            lcd_data_out,
    output logic                  accepted,
    output logic                  ready_res,

    // Configuration write port
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t                         cfg_reg;
    ctl_t                         ctl_reg;
    ctl_t                         ctl_next;
    pins_t                        pins_reg;
    pins_t                        pins_next;
    logic [TICK_COUNTER_BITS-1:0] tick_reg;
    logic [TICK_COUNTER_BITS-1:0] tick_next;
    logic                         acc_next;
    logic                         ready_next;
    logic                         out_valid_reg;
    logic                         accepted_reg;
    logic                         ready_reg;
    logic                         in_fire;

    // Stall only while a finished result is held and the sink is stalling
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup       <= 8'd2;
            cfg_reg.pulse       <= 8'd11;
            cfg_reg.hold        <= 8'd11;
            cfg_reg.first_wait  <= DUR_W'(82000);
            cfg_reg.second_wait <= DUR_W'(2000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SETUP:       cfg_reg.setup       <= cfg_data[7:0];
                CFG_PULSE:       cfg_reg.pulse       <= cfg_data[7:0];
                CFG_HOLD:        cfg_reg.hold        <= cfg_data[7:0];
                CFG_FIRST_WAIT:  cfg_reg.first_wait  <= cfg_data[DUR_W-1:0];
                CFG_SECOND_WAIT: cfg_reg.second_wait <= cfg_data[DUR_W-1:0];
                default:         ;
            endcase
        end
    end

    // One tick of sequencer logic
    clb_step #(
        .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
    ) u_step (
        .cfg         (cfg_reg),
        .ctl         (ctl_reg),
        .pins        (pins_reg),
        .tick        (tick_reg),
        .action      (action),
        .req_value   (req_value),
        .lcd_data_in (lcd_data_in),
        .ctl_next    (ctl_next),
        .pins_next   (pins_next),
        .tick_next   (tick_next),
        .accepted    (acc_next),
        .ready       (ready_next)
    );

    // Sequencer state and pin levels; these also serve as the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.phase        <= PH_WR_SETUP;
            ctl_reg.init_step    <= 3'd0;
            ctl_reg.pending_rs   <= 1'b0;
            ctl_reg.pending_byte <= 8'h00;
            ctl_reg.busy_seen    <= 1'b0;
            pins_reg             <= '0;
            tick_reg             <= '0;
            accepted_reg         <= 1'b0;
            ready_reg            <= 1'b0;
        end
        else if (in_fire)
        begin
            ctl_reg      <= ctl_next;
            pins_reg     <= pins_next;
            tick_reg     <= tick_next;
            accepted_reg <= acc_next;
            ready_reg    <= ready_next;
        end
    end

    // Result valid: set on accept, drop once the sink takes the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid    = out_valid_reg;
    assign lcd_e        = pins_reg.e;
    assign lcd_rw       = pins_reg.rw;
    assign lcd_rs       = pins_reg.rs;
    assign lcd_data_out = pins_reg.data;
    assign accepted     = accepted_reg;
    assign ready_res    = ready_reg;

endmodule

`default_nettype wire
